// ===== src/waveform_timer_channel_unit_macros.svh =====
// Assertion macros for the waveform timer channel unit
`ifndef WAVEFORM_TIMER_CHANNEL_UNIT_MACROS_SVH
`define WAVEFORM_TIMER_CHANNEL_UNIT_MACROS_SVH
`ifndef SYNTH
`define WTC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wtc assertion failed");
`define WTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wtc assertion failed");
`else
`define WTC_ASSERT_SAME(lbl, ante, cons)
`define WTC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/wtc_pkg.sv =====
// Shared types, codes and helpers of the waveform timer channel unit
package wtc_pkg;

  localparam int DATA_W = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int PRE_W = 7;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [3:0] ADDR_CTRL    = 4'd0;
  localparam logic [3:0] ADDR_MODE    = 4'd1;
  localparam logic [3:0] ADDR_COUNT   = 4'd2;
  localparam logic [3:0] ADDR_RA      = 4'd3;
  localparam logic [3:0] ADDR_RB      = 4'd4;
  localparam logic [3:0] ADDR_RC      = 4'd5;
  localparam logic [3:0] ADDR_STATUS  = 4'd6;
  localparam logic [3:0] ADDR_IRQ_SET = 4'd7;
  localparam logic [3:0] ADDR_IRQ_CLR = 4'd8;

  localparam logic [1:0] DIV_2   = 2'd0;
  localparam logic [1:0] DIV_8   = 2'd1;
  localparam logic [1:0] DIV_32  = 2'd2;
  localparam logic [1:0] DIV_128 = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        reg_addr;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              wave_a;
    logic              wave_b;
    logic              irq;
  } rsp_t;

  typedef struct packed {
    logic [1:0] div_sel;
    logic       level_a;
    logic       level_b;
    logic       flag;
    logic       irq_en;
    logic       clock_on;
  } stat_t;

  function automatic logic [PRE_W-1:0] div_limit(input logic [1:0] sel);
    logic [PRE_W-1:0] lim;
    case (sel)
      DIV_2:   lim = PRE_W'(1);
      DIV_8:   lim = PRE_W'(7);
      DIV_32:  lim = PRE_W'(31);
      DIV_128: lim = PRE_W'(127);
      default: lim = PRE_W'(1);
    endcase
    return lim;
  endfunction

endpackage

// ===== src/wtc_if.sv =====
// Request and response channel interfaces of the waveform timer channel unit
interface wtc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  reg_addr;
  logic [31:0] write_data;

  modport source (output valid, output op, output reg_addr, output write_data,
                  input ready);
  modport sink (input valid, input op, input reg_addr, input write_data,
                output ready);
endinterface

interface wtc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        wave_a;
  logic        wave_b;
  logic        irq;

  modport source (output valid, output read_data, output wave_a, output wave_b,
                  output irq, input ready);
  modport sink (input valid, input read_data, input wave_a, input wave_b,
                input irq, output ready);
endinterface

// ===== src/wtc_prescaler.sv =====
// Tick prescaler with selectable divide; it counts only on tick
module wtc_prescaler (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic [1:0] div_sel,
  output logic       fire
);
  import wtc_pkg::*;

  logic [PRE_W-1:0] pre_count;
  logic [PRE_W-1:0] pre_count_next;

  always_comb begin
    fire = tick && (pre_count >= div_limit(div_sel));
    pre_count_next = pre_count;
    if (tick) begin
      pre_count_next = fire ? '0 : pre_count + PRE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_count <= '0;
    end else begin
      pre_count <= pre_count_next;
    end
  end
endmodule

// ===== src/wtc_channel.sv =====
// Counter, compare registers, waveform levels and register file of the channel
module wtc_channel #(
  parameter int COUNT_WIDTH = wtc_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  wtc_pkg::req_t item,
  input  logic          fire,
  output wtc_pkg::rsp_t result,
  output wtc_pkg::stat_t stat
);
  import wtc_pkg::*;

  logic [COUNT_WIDTH-1:0] count_value, count_value_next;
  logic [COUNT_WIDTH-1:0] compare_a, compare_a_next;
  logic [COUNT_WIDTH-1:0] compare_b, compare_b_next;
  logic [COUNT_WIDTH-1:0] period_top, period_top_next;
  logic [3:0]             mode_bits, mode_bits_next;
  logic                   clock_on, clock_on_next;
  logic                   level_a, level_a_next;
  logic                   level_b, level_b_next;
  logic                   top_flag, top_flag_next;
  logic                   top_irq_enable, top_irq_enable_next;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [DATA_W-1:0]      rd;

  always_comb begin
    count_value_next    = count_value;
    compare_a_next      = compare_a;
    compare_b_next      = compare_b;
    period_top_next     = period_top;
    mode_bits_next      = mode_bits;
    clock_on_next       = clock_on;
    level_a_next        = level_a;
    level_b_next        = level_b;
    top_flag_next       = top_flag;
    top_irq_enable_next = top_irq_enable;
    count_inc           = count_value + COUNT_WIDTH'(1);
    rd                  = '0;
    case (item.op)
      OP_TICK: begin
        if (fire && clock_on) begin
          if (count_inc == period_top) begin
            count_value_next = '0;
            top_flag_next    = 1'b1;
            if (mode_bits[2]) level_a_next = 1'b1;
            if (mode_bits[3]) level_b_next = 1'b1;
          end else begin
            count_value_next = count_inc;
            if (mode_bits[2] && count_inc == compare_a) level_a_next = 1'b0;
            if (mode_bits[3] && count_inc == compare_b) level_b_next = 1'b0;
          end
        end
      end
      OP_READ: begin
        case (item.reg_addr)
          ADDR_MODE:    rd = DATA_W'(mode_bits);
          ADDR_COUNT:   rd = DATA_W'(count_value);
          ADDR_RA:      rd = DATA_W'(compare_a);
          ADDR_RB:      rd = DATA_W'(compare_b);
          ADDR_RC:      rd = DATA_W'(period_top);
          ADDR_STATUS: begin
            rd = DATA_W'({clock_on, top_flag});
            top_flag_next = 1'b0;
          end
          ADDR_IRQ_SET: rd = DATA_W'(top_irq_enable);
          default:      rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (item.reg_addr)
          ADDR_CTRL: begin
            if (item.write_data[0]) clock_on_next = 1'b1;
            if (item.write_data[1]) clock_on_next = 1'b0;
            if (item.write_data[2]) count_value_next = '0;
          end
          ADDR_MODE:    mode_bits_next = item.write_data[3:0];
          ADDR_RA:      compare_a_next = item.write_data[COUNT_WIDTH-1:0];
          ADDR_RB:      compare_b_next = item.write_data[COUNT_WIDTH-1:0];
          ADDR_RC:      period_top_next = item.write_data[COUNT_WIDTH-1:0];
          ADDR_IRQ_SET: if (item.write_data[0]) top_irq_enable_next = 1'b1;
          ADDR_IRQ_CLR: if (item.write_data[0]) top_irq_enable_next = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      compare_a      <= '0;
      compare_b      <= '0;
      period_top     <= '0;
      mode_bits      <= '0;
      clock_on       <= 1'b0;
      level_a        <= 1'b0;
      level_b        <= 1'b0;
      top_flag       <= 1'b0;
      top_irq_enable <= 1'b0;
    end else if (step) begin
      count_value    <= count_value_next;
      compare_a      <= compare_a_next;
      compare_b      <= compare_b_next;
      period_top     <= period_top_next;
      mode_bits      <= mode_bits_next;
      clock_on       <= clock_on_next;
      level_a        <= level_a_next;
      level_b        <= level_b_next;
      top_flag       <= top_flag_next;
      top_irq_enable <= top_irq_enable_next;
    end
  end

  always_comb begin
    result.read_data = rd;
    result.wave_a    = level_a_next;
    result.wave_b    = level_b_next;
    result.irq       = top_flag_next & top_irq_enable_next;
    stat.div_sel     = mode_bits[1:0];
    stat.level_a     = level_a;
    stat.level_b     = level_b;
    stat.flag        = top_flag;
    stat.irq_en      = top_irq_enable;
    stat.clock_on    = clock_on;
  end
endmodule

// ===== src/waveform_timer_channel_unit.sv =====
// Top level of the waveform timer channel unit: beat registers and datapath
//
//   channel | dir | payload                          | beats
//   req     | in  | op, reg_addr, write_data         | one per tick/read/write
//   rsp     | out | read_data, wave_a, wave_b, irq   | one per req beat
//
// One beat per cycle sustained while rsp is not stalled; a beat passes through
// the request register, then the response register fed by the channel logic.
// Synchronous reset clears all timer state, the prescaler and both valid flags.
// A stalled rsp holds the response register and the pending request; req stays
// ready while the response register drains in the same cycle.
module waveform_timer_channel_unit #(
  parameter int COUNT_WIDTH = wtc_pkg::COUNT_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  wtc_req_if.sink   req,
  wtc_rsp_if.source rsp
);
  import wtc_pkg::*;
  `include "waveform_timer_channel_unit_macros.svh"

  logic  pend_valid;
  req_t  pend;
  logic  out_valid;
  rsp_t  out;
  logic  adv;
  logic  step;
  logic  fire;
  rsp_t  result;
  stat_t stat;

  assign adv       = !out_valid || rsp.ready;
  assign step      = pend_valid && adv;
  assign req.ready = !pend_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      pend_valid <= 1'b1;
    end else if (step) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      pend.op         <= req.op;
      pend.reg_addr   <= req.reg_addr;
      pend.write_data <= req.write_data;
    end
  end

  wtc_prescaler u_pre (
    .clk     (clk),
    .rst     (rst),
    .tick    (step && pend.op == OP_TICK),
    .div_sel (stat.div_sel),
    .fire    (fire)
  );

  wtc_channel #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_chan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (pend),
    .fire   (fire),
    .result (result),
    .stat   (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out <= result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out.read_data;
  assign rsp.wave_a    = out.wave_a;
  assign rsp.wave_b    = out.wave_b;
  assign rsp.irq       = out.irq;

  `WTC_ASSERT_SAME(a_levels_track, out_valid, out.wave_a == stat.level_a && out.wave_b == stat.level_b)
  `WTC_ASSERT_SAME(a_irq_enabled, out_valid && out.irq, stat.irq_en && stat.flag)
  `WTC_ASSERT_NEXT(a_pend_hold, pend_valid && !adv, pend_valid)
endmodule
